### rtl/core/saturating_integer_power_unit_defines.svh
// assertion macros for the saturating integer power unit
// expects clk and rst_n in the scope where a macro is used
`ifndef SATURATING_INTEGER_POWER_UNIT_DEFINES_SVH
`define SATURATING_INTEGER_POWER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define SIPU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SIPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sipu_pkg.sv
// shared types and constants for the saturating integer power unit
// no dependencies
package sipu_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int WORD_W     = 64;
  localparam int LIMB_W     = 32;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int EXP_W      = 31;
  localparam int IN_DATA_W  = 96;

  localparam logic [WORD_W-1:0] DW_MASK   =
    WORD_W'((65'd1 << DATA_WIDTH) - 65'd1);
  localparam logic [WORD_W-1:0] MAX_VALUE =
    WORD_W'((65'd1 << (DATA_WIDTH - 1)) - 65'd1);

  localparam logic [2:0] MUL_LAST_STEP = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_SHIFT,
    ST_MUL,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef enum logic {
    MK_ACC,
    MK_SQR
  } mul_kind_t;

endpackage

### rtl/core/saturating_integer_power_unit.sv
// saturating integer power unit: base to the exponent by square-and-multiply
// depends on sipu_pkg and saturating_integer_power_unit_defines.svh

// One request at a time. The exponent is scanned from its lowest bit up, and
// every multiply (accumulator times base, or base squared) runs on a single
// shared 32x32 multiplier as four partial products summed into a 128-bit
// register. A request stops early when a product overflows. A new request is
// taken only while the unit is idle; a finished result may wait in the output
// register while the next request runs. On overflow the result is the largest
// signed value and out_tuser is set.
`include "saturating_integer_power_unit_defines.svh"

module saturating_integer_power_unit
  import sipu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // base_value [63:0], exponent [94:64], zero
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [WORD_W-1:0]    out_tdata,  // power_result [63:0]
  output logic                 out_tuser   // overflowed [0]
);

  state_t                state_r, state_nxt;
  mul_kind_t             kind_r, kind_nxt;
  logic [WORD_W-1:0]     acc_r, acc_nxt;
  logic [WORD_W-1:0]     mag_r, mag_nxt;
  logic [EXP_W-1:0]      exp_r, exp_nxt;
  logic                  neg_r, neg_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [2:0]            step_r, step_nxt;
  logic [2*LIMB_W-1:0]   pp_r, pp_nxt;
  logic [1:0]            off_r, off_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [WORD_W-1:0]     out_data_r, out_data_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic                  in_acc;
  logic                  out_free;
  logic                  prod_ovf;
  logic [WORD_W-1:0]     base_raw;
  logic                  base_neg;
  logic [WORD_W-1:0]     base_mag;
  logic [WORD_W-1:0]     op_a;
  logic [LIMB_W-1:0]     limb_a;
  logic [LIMB_W-1:0]     limb_b;
  logic [PROD_W-1:0]     pp_shifted;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ovf_r;

  // base magnitude over the working width
  assign base_raw = in_tdata[WORD_W-1:0] & DW_MASK;
  assign base_neg = in_tdata[DATA_WIDTH-1];
  assign base_mag = base_neg ? ((~base_raw + WORD_W'(1)) & DW_MASK) : base_raw;

  // shared multiplier operands
  assign op_a   = (kind_r == MK_ACC) ? acc_r : mag_r;
  assign limb_a = step_r[1] ? op_a[WORD_W-1:LIMB_W] : op_a[LIMB_W-1:0];
  assign limb_b = step_r[0] ? mag_r[WORD_W-1:LIMB_W] : mag_r[LIMB_W-1:0];

  assign prod_ovf = |prod_r[PROD_W-1:DATA_WIDTH-1];

  always_comb begin
    case (off_r)
      2'd0:    pp_shifted = {{(PROD_W-2*LIMB_W){1'b0}}, pp_r};
      2'd1:    pp_shifted = {{(PROD_W-3*LIMB_W){1'b0}}, pp_r, {LIMB_W{1'b0}}};
      2'd2:    pp_shifted = {pp_r, {(PROD_W-2*LIMB_W){1'b0}}};
      default: pp_shifted = '0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_BIT;
      end
      ST_BIT: begin
        state_nxt = exp_r[0] ? ST_MUL : ST_SHIFT;
      end
      ST_SHIFT: begin
        state_nxt = (exp_r[EXP_W-1:1] == '0) ? ST_DONE : ST_MUL;
      end
      ST_MUL: begin
        if (step_r == MUL_LAST_STEP) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (prod_ovf) begin
          state_nxt = ST_DONE;
        end else if (kind_r == MK_ACC) begin
          state_nxt = ST_SHIFT;
        end else begin
          state_nxt = ST_BIT;
        end
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    kind_nxt       = kind_r;
    acc_nxt        = acc_r;
    mag_nxt        = mag_r;
    exp_nxt        = exp_r;
    neg_nxt        = neg_r;
    ovf_nxt        = ovf_r;
    step_nxt       = step_r;
    pp_nxt         = pp_r;
    off_nxt        = off_r;
    prod_nxt       = prod_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_ovf_nxt    = out_ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          acc_nxt = WORD_W'(1);
          mag_nxt = base_mag;
          exp_nxt = in_tdata[WORD_W+EXP_W-1:WORD_W];
          neg_nxt = base_neg && in_tdata[WORD_W];
          ovf_nxt = 1'b0;
        end
      end
      ST_BIT: begin
        kind_nxt = MK_ACC;
        step_nxt = '0;
        prod_nxt = '0;
      end
      ST_SHIFT: begin
        exp_nxt  = exp_r >> 1;
        kind_nxt = MK_SQR;
        step_nxt = '0;
        prod_nxt = '0;
      end
      ST_MUL: begin
        step_nxt = step_r + 3'd1;
        if (step_r != MUL_LAST_STEP) begin
          pp_nxt  = (2*LIMB_W)'(limb_a) * (2*LIMB_W)'(limb_b);
          off_nxt = 2'(step_r[1]) + 2'(step_r[0]);
        end
        if (step_r != 3'd0) prod_nxt = prod_r + pp_shifted;
      end
      ST_EVAL: begin
        if (prod_ovf) begin
          ovf_nxt = 1'b1;
        end else if (kind_r == MK_ACC) begin
          acc_nxt = prod_r[WORD_W-1:0];
        end else begin
          mag_nxt = prod_r[WORD_W-1:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_ovf_nxt    = ovf_r;
          if (ovf_r) begin
            out_data_nxt = MAX_VALUE;
          end else if (neg_r) begin
            out_data_nxt = WORD_W'(0) - acc_r;
          end else begin
            out_data_nxt = acc_r;
          end
        end
      end
      default: begin
        step_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    acc_r      <= acc_nxt;
    mag_r      <= mag_nxt;
    exp_r      <= exp_nxt;
    neg_r      <= neg_nxt;
    ovf_r      <= ovf_nxt;
    step_r     <= step_nxt;
    pp_r       <= pp_nxt;
    off_r      <= off_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  `SIPU_ASSERT_NEXT(a_accept_starts, in_acc, state_r == ST_BIT, "request did not start scan")
  `SIPU_ASSERT_NEXT(a_operands_hold, state_r == ST_MUL && step_r != MUL_LAST_STEP,
                    $stable(acc_r) && $stable(mag_r) && $stable(kind_r),
                    "multiplier operands changed mid multiply")
  `SIPU_ASSERT_NOW(a_acc_in_range, state_r == ST_BIT || state_r == ST_SHIFT,
                   acc_r <= MAX_VALUE, "accumulator above largest value")
  `SIPU_ASSERT_NOW(a_sat_value, out_tvalid_r && out_ovf_r, out_data_r == MAX_VALUE,
                   "overflow result not saturated")

endmodule
